### src/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
package sfr_pkg;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 16;
    localparam int ByteW     = 8;
    localparam int PosW      = 5;
    localparam int FlenW     = 6;
    localparam int LimitW    = 6;
    localparam int TicksW    = 16;
    localparam int OutDataW  = 24;

    localparam logic [CfgIndexW-1:0] CFG_HEADER_CODE   = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_DEST_CODE     = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_END_CODE      = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_LENGTH_LIMIT  = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_TIMEOUT_TICKS = 3'd4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_HEAD = 3'd0,
        ST_DEST = 3'd1,
        ST_LEN  = 3'd2,
        ST_PAY  = 3'd3,
        ST_SUM  = 3'd4,
        ST_END  = 3'd5,
        ST_RD   = 3'd6,
        ST_LD   = 3'd7
    } t_state;

    typedef struct packed {
        logic load_timer;
        logic dec_timer;
        logic clr_count;
        logic inc_count;
        logic sum_load;
        logic sum_add;
        logic sum_clr;
        logic len_load;
        logic ram_we;
        logic emit_clr;
        logic emit_inc;
        logic rd_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hdr_match;
        logic dst_match;
        logic len_bad;
        logic len_zero;
        logic count_done;
        logic sum_match;
        logic end_match;
        logic timeout_zero;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

### src/serial_frame_receiver_core.sv
// Top level of the serial frame receiver.
//
//   channel   dir  handshake                  payload
//   s_        in   i_s_tvalid / o_s_tready    tdata: byte_value; tuser: kind
//   m_        out  o_m_tvalid / i_m_tready    tdata: payload_byte, byte_position,
//                                             frame_length; tlast: is_last
//   cfg_      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A byte or tick beat is taken in any receive state. After a good end byte the payload
// is walked out of the store: each byte is read from the registered store, then loaded
// into the output register, waiting while the output stalls; input is held off until
// the last byte is loaded. Reset is synchronous, active low; output data is not reset.
module serial_frame_receiver_core
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32,
    parameter int TIMER_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [ByteW-1:0]     i_s_tdata,   // [7:0] byte_value
    input  logic                 i_s_tuser,   // [0] kind
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OutDataW-1:0]  o_m_tdata,   // [7:0] payload_byte, [12:8] byte_position,
                                              // [18:13] frame_length
    output logic                 o_m_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic ready;
    logic beat;

    assign beat        = i_s_tvalid && ready;
    assign o_s_tready  = ready;
    assign o_cfg_ready = 1'b1;

    sfr_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_beat (beat),
        .i_kind (i_s_tuser),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_ready(ready)
    );

    sfr_dp #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_byte     (i_s_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

### src/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/sfr_ctrl.sv
// Frame phase and payload emission controller.
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_beat,
    input  logic i_kind,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    t_state r_state;
    t_state n_state;
    t_state eff;

    assign eff = i_sts.timeout_zero ? ST_HEAD : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_HEAD, ST_DEST, ST_LEN, ST_PAY, ST_SUM, ST_END: begin
                if (i_beat && i_kind == KIND_BYTE) begin
                    case (eff)
                        ST_HEAD: begin
                            n_state = i_sts.hdr_match ? ST_DEST : ST_HEAD;
                        end
                        ST_DEST: begin
                            n_state = i_sts.dst_match ? ST_LEN : ST_HEAD;
                        end
                        ST_LEN: begin
                            if (i_sts.len_bad) begin
                                n_state = ST_HEAD;
                            end else if (!i_sts.len_zero) begin
                                n_state = ST_PAY;
                            end else begin
                                n_state = ST_LEN;
                            end
                        end
                        ST_PAY: begin
                            n_state = i_sts.count_done ? ST_SUM : ST_PAY;
                        end
                        ST_SUM: begin
                            n_state = i_sts.sum_match ? ST_END : ST_HEAD;
                        end
                        ST_END: begin
                            n_state = i_sts.end_match ? ST_RD : ST_HEAD;
                        end
                        default: begin
                            n_state = ST_HEAD;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_state = ST_LD;
            end
            ST_LD: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.emit_last ? ST_HEAD : ST_RD;
                end
            end
            default: begin
                n_state = ST_HEAD;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_HEAD, ST_DEST, ST_LEN, ST_PAY, ST_SUM, ST_END: begin
                o_ready = 1'b1;
                if (i_beat && i_kind == KIND_TICK) begin
                    o_cmd.dec_timer = !i_sts.timeout_zero;
                end else if (i_beat) begin
                    if (i_sts.timeout_zero) begin
                        o_cmd.clr_count = 1'b1;
                        o_cmd.sum_clr   = 1'b1;
                    end
                    case (eff)
                        ST_HEAD: begin
                            if (i_sts.hdr_match) begin
                                o_cmd.clr_count  = 1'b1;
                                o_cmd.load_timer = 1'b1;
                            end
                        end
                        ST_DEST: begin
                            o_cmd.sum_load = i_sts.dst_match;
                        end
                        ST_LEN: begin
                            if (!i_sts.len_bad && !i_sts.len_zero) begin
                                o_cmd.len_load = 1'b1;
                                o_cmd.sum_add  = 1'b1;
                            end
                        end
                        ST_PAY: begin
                            o_cmd.ram_we    = 1'b1;
                            o_cmd.sum_add   = 1'b1;
                            o_cmd.clr_count = i_sts.count_done;
                            o_cmd.inc_count = !i_sts.count_done;
                        end
                        ST_SUM: begin
                            o_cmd.sum_clr = !i_sts.sum_match;
                        end
                        ST_END: begin
                            o_cmd.emit_clr = i_sts.end_match;
                        end
                        default: begin
                            o_cmd = '0;
                        end
                    endcase
                end
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            ST_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.emit_inc = !i_sts.emit_last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_rd_then_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RD |=> r_state == ST_LD)
        else $error("read not followed by load");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register overwritten");

    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD || r_state == ST_LD) |-> !i_beat)
        else $error("input taken during emission");

endmodule

### src/sfr_dp.sv
// Datapath: configuration, counters, checksum, payload store and output register.
module sfr_dp
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32,
    parameter int TIMER_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    input  logic [ByteW-1:0]     i_byte,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [OutDataW-1:0]  o_m_tdata,
    output logic                 o_m_tlast
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [ByteW:0] MaxLen = (ByteW + 1)'(MAX_PAYLOAD);

    logic [ByteW-1:0]      r_hdr_code;
    logic [ByteW-1:0]      r_dst_code;
    logic [ByteW-1:0]      r_end_code;
    logic [LimitW-1:0]     r_limit;
    logic [TicksW-1:0]     r_ticks;
    logic [TIMER_BITS-1:0] r_timer;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_len;
    logic [ByteW-1:0]      r_sum;
    logic [AW-1:0]         r_emit;
    logic                  r_out_valid;
    logic [ByteW-1:0]      r_out_byte;
    logic [PosW-1:0]       r_out_pos;
    logic [FlenW-1:0]      r_out_flen;
    logic                  r_out_last;

    logic [47:0]           ticks_wide;
    logic [31:0]           emit_wide;
    logic [31:0]           len_wide;
    logic [ByteW-1:0]      rdata;
    logic [CW:0]           count_next;
    logic [CW:0]           emit_next;

    assign ticks_wide = 48'(r_ticks);
    assign emit_wide  = 32'(r_emit);
    assign len_wide   = 32'(r_len);
    assign count_next = (CW + 1)'(r_count) + (CW + 1)'(1);
    assign emit_next  = (CW + 1)'(r_emit) + (CW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_code <= '0;
            r_dst_code <= '0;
            r_end_code <= '0;
            r_limit    <= LimitW'(32);
            r_ticks    <= TicksW'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER_CODE:   r_hdr_code <= i_cfg_data[ByteW-1:0];
                CFG_DEST_CODE:     r_dst_code <= i_cfg_data[ByteW-1:0];
                CFG_END_CODE:      r_end_code <= i_cfg_data[ByteW-1:0];
                CFG_LENGTH_LIMIT:  r_limit    <= i_cfg_data[LimitW-1:0];
                CFG_TIMEOUT_TICKS: r_ticks    <= i_cfg_data[TicksW-1:0];
                default: begin
                    r_limit <= r_limit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= '0;
            r_count     <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_timer) begin
                r_timer <= ticks_wide[TIMER_BITS-1:0];
            end else if (i_cmd.dec_timer) begin
                r_timer <= r_timer - TIMER_BITS'(1);
            end
            if (i_cmd.inc_count) begin
                r_count <= count_next[CW-1:0];
            end else if (i_cmd.clr_count) begin
                r_count <= '0;
            end
            if (i_cmd.len_load) begin
                r_len <= i_byte[CW-1:0];
            end
            if (i_cmd.sum_load) begin
                r_sum <= i_byte;
            end else if (i_cmd.sum_add) begin
                r_sum <= r_sum + i_byte;
            end else if (i_cmd.sum_clr) begin
                r_sum <= '0;
            end
            if (i_cmd.emit_clr) begin
                r_emit <= '0;
            end else if (i_cmd.emit_inc) begin
                r_emit <= r_emit + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte <= rdata;
            r_out_pos  <= emit_wide[PosW-1:0];
            r_out_flen <= len_wide[FlenW-1:0];
            r_out_last <= (emit_next == (CW + 1)'(r_len));
        end
    end

    sfr_ram #(
        .WIDTH(ByteW),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_byte),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(r_emit),
        .o_rdata(rdata)
    );

    always_comb begin
        o_sts.hdr_match    = (i_byte == r_hdr_code);
        o_sts.dst_match    = (i_byte == r_dst_code);
        o_sts.len_bad      = ({1'b0, i_byte} > (ByteW + 1)'(r_limit)) ||
                             ({1'b0, i_byte} > MaxLen);
        o_sts.len_zero     = (i_byte == '0);
        o_sts.count_done   = (count_next >= (CW + 1)'(r_len));
        o_sts.sum_match    = (r_sum == i_byte);
        o_sts.end_match    = (i_byte == r_end_code);
        o_sts.timeout_zero = (r_timer == '0);
        o_sts.emit_last    = (emit_next == (CW + 1)'(r_len));
        o_sts.out_free     = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OutDataW - ByteW - PosW - FlenW)'(0), r_out_flen, r_out_pos,
                         r_out_byte};
    assign o_m_tlast  = r_out_last;

    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ram_we |-> (32'(r_count) < MAX_PAYLOAD))
        else $error("payload write beyond store");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= MAX_PAYLOAD)
        else $error("payload length beyond store");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_m_tvalid)
        else $error("loaded beat not presented");

endmodule

### tb/sv/sfr_frame_checker.sv
// Checker for the serial frame receiver: tracks frames, predicts payload beats, compares.
module sfr_frame_checker
    import sfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [ByteW-1:0]     i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [OutDataW-1:0]  i_m_tdata,
    input  logic                 i_m_tlast,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxPayload = 32;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic [PosW-1:0]  pos;
        logic [FlenW-1:0] flen;
        logic             last;
    } t_frame_byte;

    t_frame_byte expected_payload[$];
    t_frame_byte want;
    int          errs;

    logic [ByteW-1:0]  hdr_code;
    logic [ByteW-1:0]  dst_code;
    logic [ByteW-1:0]  end_code;
    logic [LimitW-1:0] len_limit;
    logic [TicksW-1:0] timeout_load;

    t_state            phase;
    logic [5:0]        rx_count;
    logic [FlenW-1:0]  frame_len;
    logic [ByteW-1:0]  frame_sum;
    logic [ByteW-1:0]  payload_buf [MaxPayload];
    logic [TicksW-1:0] timer_left;

    task automatic deframe_item(input logic kind, input logic [ByteW-1:0] b);
        t_frame_byte fb;
        int          i;
        if (kind == KIND_TICK) begin
            if (timer_left != '0) timer_left = timer_left - 1'b1;
        end else begin
            if (timer_left == '0) begin
                phase     = ST_HEAD;
                rx_count  = '0;
                frame_sum = '0;
            end
            case (phase)
                ST_HEAD: begin
                    if (b == hdr_code) begin
                        phase      = ST_DEST;
                        rx_count   = '0;
                        timer_left = timeout_load;
                    end
                end
                ST_DEST: begin
                    if (b == dst_code) begin
                        phase     = ST_LEN;
                        frame_sum = b;
                    end else begin
                        phase = ST_HEAD;
                    end
                end
                ST_LEN: begin
                    if (b > {2'b00, len_limit} || int'(b) > MaxPayload) begin
                        phase = ST_HEAD;
                    end else if (b != '0) begin
                        frame_len = b[FlenW-1:0];
                        phase     = ST_PAY;
                        frame_sum = frame_sum + b;
                    end
                end
                ST_PAY: begin
                    if (int'(rx_count) < MaxPayload) payload_buf[rx_count] = b;
                    frame_sum = frame_sum + b;
                    rx_count  = rx_count + 1'b1;
                    if (rx_count >= frame_len) begin
                        phase    = ST_SUM;
                        rx_count = '0;
                    end
                end
                ST_SUM: begin
                    if (frame_sum != b) begin
                        frame_sum = '0;
                        phase     = ST_HEAD;
                    end else begin
                        phase = ST_END;
                    end
                end
                ST_END: begin
                    if (b == end_code) begin
                        for (i = 0; i < int'(frame_len) && i < MaxPayload; i++) begin
                            fb.data = payload_buf[i];
                            fb.pos  = PosW'(i);
                            fb.flen = frame_len;
                            fb.last = (i + 1 == int'(frame_len));
                            expected_payload.push_back(fb);
                        end
                    end
                    phase = ST_HEAD;
                end
                default: phase = ST_HEAD;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hdr_code     = '0;
            dst_code     = '0;
            end_code     = '0;
            len_limit    = 6'd32;
            timeout_load = 16'd100;
            phase        = ST_HEAD;
            rx_count     = '0;
            frame_len    = '0;
            frame_sum    = '0;
            timer_left   = '0;
            expected_payload.delete();
            o_fail_count <= 0;
        end else begin
            errs = 0;
            if (i_m_tvalid && i_m_tready) begin
                if (expected_payload.size() == 0) begin
                    $error("payload beat with nothing expected: tdata %0h tlast %0b",
                           i_m_tdata, i_m_tlast);
                    errs++;
                end else begin
                    want = expected_payload.pop_front();
                    if (i_m_tdata[7:0] != want.data) begin
                        $error("payload_byte expected %0h actual %0h",
                               want.data, i_m_tdata[7:0]);
                        errs++;
                    end
                    if (i_m_tdata[12:8] != want.pos) begin
                        $error("byte_position expected %0d actual %0d",
                               want.pos, i_m_tdata[12:8]);
                        errs++;
                    end
                    if (i_m_tdata[18:13] != want.flen) begin
                        $error("frame_length expected %0d actual %0d",
                               want.flen, i_m_tdata[18:13]);
                        errs++;
                    end
                    if (i_m_tlast != want.last) begin
                        $error("is_last expected %0b actual %0b", want.last, i_m_tlast);
                        errs++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) deframe_item(i_s_tuser, i_s_tdata);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEADER_CODE:   hdr_code     = i_cfg_data[ByteW-1:0];
                    CFG_DEST_CODE:     dst_code     = i_cfg_data[ByteW-1:0];
                    CFG_END_CODE:      end_code     = i_cfg_data[ByteW-1:0];
                    CFG_LENGTH_LIMIT:  len_limit    = i_cfg_data[LimitW-1:0];
                    CFG_TIMEOUT_TICKS: timeout_load = i_cfg_data[TicksW-1:0];
                    default: ;
                endcase
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_payload.size();
    end

endmodule

### tb/sv/serial_frame_receiver_core_test.sv
// Testbench top for the serial frame receiver: clock, reset, stimulus and verdict.
module serial_frame_receiver_core_test;
    import sfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems  = 180;
    localparam int PhaseItems   = 40;
    localparam int SettleCycles = 24;
    localparam int CycleLimit   = 300000;

    logic                 i_clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [ByteW-1:0]     s_tdata   = '0;
    logic                 s_tuser   = KIND_BYTE;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = CFG_HEADER_CODE;
    logic [CfgDataW-1:0]  cfg_data  = '0;

    logic                 s_tready;
    logic                 m_tvalid;
    logic [OutDataW-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_ready;

    int                   fail_count;
    int                   pending;
    int                   items_sent   = 0;
    int                   cycle_count  = 0;

    logic [ByteW-1:0]     cur_hdr;
    logic [ByteW-1:0]     cur_dst;
    logic [ByteW-1:0]     cur_end;
    int                   cur_limit;
    int                   tick_pct = 0;
    logic                 tx_burst = 1'b0;
    logic                 rx_burst = 1'b0;
    int unsigned          rx_gap;
    int unsigned          stall_left = 0;

    serial_frame_receiver_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sfr_frame_checker frame_chk (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                rx_gap = rx_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 15) == 0) rx_burst <= ~rx_burst;
                if (rx_gap != 0) begin
                    m_tready   <= 1'b0;
                    stall_left <= rx_gap - 1;
                end
            end
        end else if (stall_left == 0) begin
            m_tready <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    task automatic send_item(input logic kind, input logic [ByteW-1:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b);
        send_item(KIND_BYTE, b);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, ByteW'($urandom));
    endtask

    // sprinkle ticks between bytes at the phase's rate
    task automatic send_frame_byte(input logic [ByteW-1:0] b);
        if ($urandom_range(0, 99) < tick_pct) send_tick();
        send_byte(b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [ByteW-1:0] h, input logic [ByteW-1:0] d,
                              input logic [ByteW-1:0] e, input int lim,
                              input logic [TicksW-1:0] ticks);
        write_reg(CFG_HEADER_CODE, CfgDataW'(h));
        write_reg(CFG_DEST_CODE, CfgDataW'(d));
        write_reg(CFG_END_CODE, CfgDataW'(e));
        write_reg(CFG_LENGTH_LIMIT, CfgDataW'(lim));
        write_reg(CFG_TIMEOUT_TICKS, CfgDataW'(ticks));
        cfg_valid <= 1'b0;
        cur_hdr   = h;
        cur_dst   = d;
        cur_end   = e;
        cur_limit = lim;
    endtask

    // mostly well-formed frames; some break at the destination, length, checksum or end
    task automatic send_frame();
        logic [FlenW-1:0] flen;
        logic [ByteW-1:0] csum;
        logic [ByteW-1:0] pay;
        int               fault;
        int               max_len;
        max_len  = (cur_limit < 6) ? cur_limit : 6;
        flen     = ($urandom_range(0, 9) == 0) ? FlenW'(cur_limit)
                                               : FlenW'($urandom_range(1, max_len));
        fault    = $urandom_range(0, 9);
        tx_burst = ($urandom_range(0, 3) == 0);
        send_frame_byte(cur_hdr);
        if (fault == 6) begin
            send_frame_byte(cur_dst ^ ByteW'($urandom_range(1, 255)));
        end else begin
            send_frame_byte(cur_dst);
            if ($urandom_range(0, 3) == 0) send_frame_byte(8'h00);
            if (fault == 7) begin
                send_frame_byte(ByteW'($urandom_range(cur_limit + 1, 255)));
            end else begin
                send_frame_byte({2'b00, flen});
                csum = cur_dst + {2'b00, flen};
                repeat (flen) begin
                    pay  = ByteW'($urandom);
                    csum = csum + pay;
                    send_frame_byte(pay);
                end
                if (fault == 8) begin
                    send_frame_byte(csum ^ ByteW'($urandom_range(1, 255)));
                end else begin
                    send_frame_byte(csum);
                    send_frame_byte((fault == 9) ? cur_end ^ ByteW'($urandom_range(1, 255))
                                                 : cur_end);
                end
            end
        end
    endtask

    initial begin
        int ph;
        int random_start;
        int phase_end;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(8'hA5, 8'h3C, 8'h7E, 32, 16'd2);
        send_byte(8'hA5); send_byte(8'h00);
        send_byte(8'hA5); send_byte(8'h3C); send_byte(8'h21);
        send_byte(8'hA5); send_byte(8'h3C); send_byte(8'h01); send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5); send_tick(); send_tick(); send_byte(8'h3C);
        send_byte(8'hA5); send_byte(8'h3C); send_byte(8'h00); send_byte(8'h01);
        send_byte(8'hFF); send_byte(8'h3C); send_byte(8'h7E);
        send_byte(8'hA5); send_byte(8'h3C); send_byte(8'h01); send_byte(8'h00);
        send_byte(8'h3D); send_byte(8'hFF);
        drain();

        ph = 0;
        random_start = items_sent;
        while ((items_sent - random_start) < RandomItems) begin
            case (ph)
                0: begin
                    set_config(8'h00, 8'hFF, 8'h00, 32, 16'hFFFF);
                    tick_pct = 5;
                end
                1: begin
                    set_config(8'hFF, 8'h00, 8'hFF, 1, 16'hFFFF);
                    tick_pct = 5;
                end
                2: begin
                    set_config(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                               $urandom_range(1, 32), 16'd0);
                    tick_pct = 10;
                end
                default: begin
                    set_config(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                               $urandom_range(1, 32),
                               (ph % 2 != 0) ? TicksW'($urandom_range(1, 6))
                                             : TicksW'($urandom_range(20, 1000)));
                    tick_pct = $urandom_range(0, 20);
                end
            endcase
            phase_end = items_sent + PhaseItems;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 3)) send_frame_byte(ByteW'($urandom));
                end
                send_frame();
            end
            drain();
            ph++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/sfr_pkg.sv
src/sfr_ram.sv
src/sfr_ctrl.sv
src/sfr_dp.sv
src/serial_frame_receiver_core.sv
tb/sv/sfr_frame_checker.sv
tb/sv/serial_frame_receiver_core_test.sv
